### hdl/cse_pkg.sv
// cse_pkg: shared types, constants and helpers for the Chebyshev series evaluator.
// Used by cse_ctrl, cse_dpath and chebyshev_series_evaluator; depends on nothing.
package cse_pkg;

  localparam int MAX_TERMS = 16;

  // Dividend magnitude: |2x - a - b| < 2^33, shifted left by 16 fraction bits.
  localparam int DIV_BITS  = 49;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // Widest intermediate of the recurrence: 2*(y*b1 >> 16) - b2 + c.
  localparam int ACC_W = 52;

  localparam logic signed [ACC_W-1:0] SAT_HI = 52'sh0_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = 52'shF_FFFF_8000_0000;

  // Input item action codes
  localparam logic ACT_EVAL = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_TERMS = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_coef;  // write one table slot
    logic start;      // capture operands, set up the divider
    logic div_step;   // one quotient bit
    logic norm;       // sign-correct and clip the quotient into y
    logic mul;        // register y * b1
    logic acc;        // one recurrence step (or the final sum when last)
    logic last;
    logic out_load;   // move the result into the output register
  } cse_cmd_t;

  typedef struct packed {
    logic              flag;
    logic signed [31:0] value;
  } cse_clip_t;

  function automatic cse_clip_t clip32(input logic signed [ACC_W-1:0] v);
    cse_clip_t r;
    if (v > SAT_HI) begin
      r.flag  = 1'b1;
      r.value = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r.flag  = 1'b1;
      r.value = 32'sh8000_0000;
    end else begin
      r.flag  = 1'b0;
      r.value = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/cse_ram.sv
// cse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  logic [Width-1:0]                         wr_data,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic [Width-1:0]                         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/cse_dpath.sv
// cse_dpath: config registers, coefficient table, restoring divider and
// multiply-accumulate for the Clenshaw recurrence. Uses cse_pkg and cse_ram.
module cse_dpath #(
  parameter int MaxTerms = cse_pkg::MAX_TERMS,
  parameter int IdxW     = (MaxTerms > 1) ? $clog2(MaxTerms) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cse_pkg::cse_cmd_t  cmd,
  input  logic [IdxW-1:0]    rd_addr,
  output logic [IdxW-1:0]    first_idx,
  output logic               empty_interval,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] x_value,
  output logic signed [31:0] series_value,
  output logic               saturated,
  output logic               range_error
);

  localparam int AW = cse_pkg::ACC_W;
  localparam int DB = cse_pkg::DIV_BITS;

  // configuration
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic [4:0]         term_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
      upper_bound <= 32'sd65536;
      term_count  <= 5'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cse_pkg::CFG_LOWER: lower_bound <= cfg_data;
        cse_pkg::CFG_UPPER: upper_bound <= cfg_data;
        cse_pkg::CFG_TERMS: term_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign empty_interval = (upper_bound == lower_bound);

  always_comb begin
    if (term_count == 5'd0) begin
      first_idx = '0;
    end else if (32'(term_count) > 32'(MaxTerms)) begin
      first_idx = IdxW'(MaxTerms - 1);
    end else begin
      first_idx = IdxW'(term_count - 5'd1);
    end
  end

  // coefficient table; valid bits stand in for the cleared state
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [31:0]         ram_q;
  logic [MaxTerms-1:0] coef_valid;
  logic                valid_q;
  logic signed [31:0]  coef;

  assign wr_en   = cmd.load_coef && (32'(coef_index) < 32'(MaxTerms));
  assign wr_addr = IdxW'(coef_index);

  cse_ram #(
    .Width(32),
    .Depth(MaxTerms)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(coef_value),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        coef_valid[wr_addr] <= 1'b1;
      end
      valid_q <= coef_valid[rd_addr];
    end
  end

  assign coef = valid_q ? ram_q : 32'sd0;

  // operand setup: num = 2x - a - b, den = b - a
  logic signed [34:0] num;
  logic signed [32:0] den;
  logic [32:0]        num_mag;
  logic [31:0]        den_mag;

  assign num = {{2{x_value[31]}}, x_value, 1'b0}
             - {{3{lower_bound[31]}}, lower_bound}
             - {{3{upper_bound[31]}}, upper_bound};
  assign den = {upper_bound[31], upper_bound} - {lower_bound[31], lower_bound};

  always_comb begin
    logic signed [34:0] nneg;
    logic signed [32:0] dneg;
    nneg    = -num;
    dneg    = -den;
    num_mag = num[34] ? nneg[32:0] : num[32:0];
    den_mag = den[32] ? dneg[31:0] : den[31:0];
  end

  // restoring divider, one quotient bit per step
  logic [DB-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   divisor;
  logic          q_neg;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DB-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // recurrence
  logic signed [31:0] y;
  logic signed [31:0] b1;
  logic signed [31:0] b2;
  logic signed [63:0] prod;
  logic signed [47:0] p_shr;
  logic               sat;
  logic               range_err;
  logic signed [AW-1:0] step_sum;
  logic signed [AW-1:0] final_sum;
  cse_pkg::cse_clip_t   clip_step;
  cse_pkg::cse_clip_t   clip_final;

  assign p_shr = prod[63:16];   // floor shift

  assign step_sum  = {{3{p_shr[47]}}, p_shr, 1'b0}
                   - {{(AW-32){b2[31]}}, b2}
                   + {{(AW-32){coef[31]}}, coef};
  assign final_sum = {{(AW-48){p_shr[47]}}, p_shr}
                   - {{(AW-32){b2[31]}}, b2}
                   + {{(AW-31){coef[31]}}, coef[31:1]};

  assign clip_step  = cse_pkg::clip32(step_sum);
  assign clip_final = cse_pkg::clip32(final_sum);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      range_err <= empty_interval;
      sat       <= 1'b0;
      b1        <= '0;
      b2        <= '0;
      quo       <= {num_mag, 16'b0};
      rem       <= '0;
      divisor   <= den_mag;
      q_neg     <= num[34] ^ den[32];
    end
    if (cmd.div_step) begin
      rem <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      quo <= {quo[DB-2:0], fits};
    end
    if (cmd.norm) begin
      if (!q_neg && (quo > DB'(32'h7FFF_FFFF))) begin
        y   <= 32'sh7FFF_FFFF;
        sat <= 1'b1;
      end else if (q_neg && (quo > DB'(32'h8000_0000))) begin
        y   <= 32'sh8000_0000;
        sat <= 1'b1;
      end else begin
        y <= q_neg ? -quo[31:0] : quo[31:0];
      end
    end
    if (cmd.mul) begin
      prod <= y * b1;
    end
    if (cmd.acc) begin
      if (cmd.last) begin
        b1  <= clip_final.value;
        sat <= sat | clip_final.flag;
      end else begin
        b2  <= b1;
        b1  <= clip_step.value;
        sat <= sat | clip_step.flag;
      end
    end
    if (cmd.out_load) begin
      series_value <= range_err ? 32'sd0 : b1;
      saturated    <= range_err ? 1'b0 : sat;
      range_error  <= range_err;
    end
  end

endmodule

### hdl/cse_ctrl.sv
// cse_ctrl: sequencer for load, divide, recurrence and result delivery.
// Uses cse_pkg; drives cse_dpath through cse_cmd_t.
module cse_ctrl #(
  parameter int MaxTerms = cse_pkg::MAX_TERMS,
  parameter int IdxW     = (MaxTerms > 1) ? $clog2(MaxTerms) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              empty_interval,
  input  logic [IdxW-1:0]   first_idx,
  output cse_pkg::cse_cmd_t cmd,
  output logic [IdxW-1:0]   rd_addr
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_NORM,
    ST_MUL,
    ST_ACC,
    ST_DELIVER
  } state_t;

  state_t                         state;
  logic [cse_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [IdxW-1:0]                idx;

  assign in_stall = (state != ST_IDLE);
  assign rd_addr  = idx;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_coef = (action == cse_pkg::ACT_LOAD);
          cmd.start     = (action == cse_pkg::ACT_EVAL);
        end
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_NORM:   cmd.norm     = 1'b1;
      ST_MUL:    cmd.mul      = 1'b1;
      ST_ACC: begin
        cmd.acc  = 1'b1;
        cmd.last = (idx == '0);
      end
      ST_DELIVER: cmd.out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
      idx       <= '0;
    end else begin
      // a new result replaces the old one in the cycle it transfers
      if ((state == ST_DELIVER) && cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            div_cnt <= cse_pkg::DIV_CNT_W'(cse_pkg::DIV_BITS - 1);
            state   <= empty_interval ? ST_DELIVER : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_cnt == '0) begin
            state <= ST_NORM;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_NORM: begin
          idx   <= first_idx;
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          if (idx == '0) begin
            state <= ST_DELIVER;
          end else begin
            idx   <= idx - 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DELIVER: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/chebyshev_series_evaluator.sv
// chebyshev_series_evaluator: top level, Clenshaw evaluation of a Chebyshev series.
// Uses cse_pkg, cse_ctrl, cse_dpath (which holds cse_ram).
//
// Usage:
//  - Input channel (in_valid / in_stall): a transfer with action = load writes
//    coef_value into table slot coef_index (slots at or above MaxTerms are
//    dropped) and gives no result; action = evaluate computes the series at x_value.
//  - Output channel (out_valid / out_stall): one transfer per evaluate item,
//    carrying series_value (Q16.16, saturated), saturated and range_error.
//  - Config port: cfg_write with cfg_index 0 lower bound, 1 upper bound,
//    2 term count; indexes past the list are ignored. Write only when idle.
//  - Sequence: a load needs no further steps. An evaluate runs the 49-step
//    restoring divider (one quotient bit per cycle), a normalize step, then
//    for each of n terms a registered multiply, then an add and clip, then
//    the move into the output register. An empty interval skips all of that
//    and goes straight to delivery.
//  - One item is in work at a time; in_stall is high while it is.
//    The output register lets the next item be taken while a result waits.
//  - If out_stall holds a result back when the next one is ready, the block
//    waits in its delivery step until the old result has transferred.
//  - Reset clears the table to zero, sets the bounds to [0, 1.0) and the
//    term count to 1, and empties the output register.
module chebyshev_series_evaluator #(
  parameter int MaxTerms = cse_pkg::MAX_TERMS
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] x_value,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] series_value,
  output logic               saturated,
  output logic               range_error,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;

  cse_pkg::cse_cmd_t cmd;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   first_idx;
  logic              empty_interval;

  // sequencer: owns the handshakes and the term / divide counters
  cse_ctrl #(
    .MaxTerms(MaxTerms),
    .IdxW    (IdxW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .empty_interval(empty_interval),
    .first_idx     (first_idx),
    .cmd           (cmd),
    .rd_addr       (rd_addr)
  );

  // arithmetic, table and config registers
  cse_dpath #(
    .MaxTerms(MaxTerms),
    .IdxW    (IdxW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .first_idx     (first_idx),
    .empty_interval(empty_interval),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .x_value       (x_value),
    .series_value  (series_value),
    .saturated     (saturated),
    .range_error   (range_error)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for chebyshev_series_evaluator.
// Depends on cse_pkg and the evaluator RTL; directed table, then randomized phases.

module testbench;

  localparam int RAND_ITEMS    = 1150;
  localparam int SETTLE_CYCLES = 100;   // margin above the longest evaluate
  localparam int HOLD_CYCLES   = 600;   // one long output hold-off
  localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on either side

  localparam logic [1:0] CFG_SPARE = 2'd3;                // past the register list, ignored
  localparam logic [1:0] NO_REG    = cse_pkg::CFG_LOWER;  // don't-care index on item rows

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint Q_MAX = longint'(32'sh7FFF_FFFF);
  localparam longint Q_MIN = longint'(32'sh8000_0000);

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
    logic               rerr;
  } series_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_t;
  typedef enum logic [1:0] {FLOW, LIGHT, HALF, HEAVY} stall_mode_t;
  typedef enum logic [2:0] {
    SPAN_SYMMETRIC, SPAN_UNIT, SPAN_RANDOM, SPAN_REVERSED, SPAN_FULL, SPAN_EMPTY, SPAN_TINY
  } span_kind_t;

  // One directed step: a config write or an input item. The typed result is
  // used only when known is set; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [3:0]  slot;
    logic [31:0] data;       // coefficient for loads, register value for writes
    logic [31:0] x;
    logic        known;
    logic [31:0] exp_value;
    logic        exp_sat;
    logic        exp_rerr;
  } stim_row_t;

  localparam stim_row_t DIRECTED [33] = '{
    // reset state: empty table, term count 1 -> zero
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_0000, 1'b1, 'h0000_0000, 1'b0, 1'b0},
    // largest c0, x far outside the interval: y clips, result c0/2
    '{ROW_LOAD, NO_REG, 4'd0,  'h7FFF_FFFF, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h7FFF_FFFF, 1'b1, 'h3FFF_FFFF, 1'b1, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd0,  'h8000_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h8000_0000, 1'b1, 'hC000_0000, 1'b1, 1'b0},
    // midpoint, y = 0
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_8000, 1'b1, 'hC000_0000, 1'b0, 1'b0},
    // term count zero acts as one
    '{ROW_CFG,  cse_pkg::CFG_TERMS, 4'd0, 'h0000_0000, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_0000, 1'b1, 'hC000_0000, 1'b0, 1'b0},
    // term count above the table size acts as the table size
    '{ROW_CFG,  cse_pkg::CFG_TERMS, 4'd0, 'h0000_001F, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd15, 'h7FFF_FFFF, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd1,  'h0001_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd0,  'h0002_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0001_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_8000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    // empty interval: range error, zero result
    '{ROW_CFG,  cse_pkg::CFG_UPPER, 4'd0, 'h0000_0000, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_1234, 1'b1, 'h0000_0000, 1'b0, 1'b1},
    '{ROW_CFG,  cse_pkg::CFG_LOWER, 4'd0, 'h8000_0000, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_CFG,  cse_pkg::CFG_UPPER, 4'd0, 'h8000_0000, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h7FFF_FFFF, 1'b1, 'h0000_0000, 1'b0, 1'b1},
    // write past the register list changes nothing
    '{ROW_CFG,  CFG_SPARE, 4'd0, 'h1234_5678, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_0000, 1'b1, 'h0000_0000, 1'b0, 1'b1},
    // widest interval
    '{ROW_CFG,  cse_pkg::CFG_UPPER, 4'd0, 'h7FFF_FFFF, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h8000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h7FFF_FFFF, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    // narrowest interval, one LSB wide: y clips almost everywhere
    '{ROW_CFG,  cse_pkg::CFG_TERMS, 4'd0, 'h0000_0010, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_CFG,  cse_pkg::CFG_LOWER, 4'd0, 'h0000_0000, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_CFG,  cse_pkg::CFG_UPPER, 4'd0, 'h0000_0001, 'h0000_0000, 1'b0, 'h0000_0000,
      1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h7FFF_FFFF, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd14, 'h8000_0000, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_LOAD, NO_REG, 4'd7,  'hFFFF_FFFF, 'h0000_0000, 1'b0, 'h0000_0000, 1'b0, 1'b0},
    '{ROW_EVAL, NO_REG, 4'd0,  'h0000_0000, 'h5555_5555, 1'b0, 'h0000_0000, 1'b0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] x_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] series_value;
  logic               saturated;
  logic               range_error;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  // Shadow of the block's registers and coefficient table
  logic signed [31:0] lo_bound = 32'sd0;
  logic signed [31:0] hi_bound = Q_ONE;
  logic [4:0]         term_reg = 5'd1;
  logic signed [31:0] coef_tab [cse_pkg::MAX_TERMS];

  series_result_t pending [$];  // expected results, oldest first
  int fails       = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit hold_req    = 1'b0;

  always #2 clk = ~clk;

  chebyshev_series_evaluator DUT (.*);

  // Saturate to Q16.16, latching the clip flag.
  function automatic longint clamp_q16(input longint v, inout bit clipped);
    if (v > Q_MAX) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // Clenshaw sum at x under the shadow configuration. All intermediates fit in
  // 64 bits; >>> on a signed longint floors, / truncates toward zero.
  function automatic series_result_t clenshaw_eval(input logic signed [31:0] x);
    series_result_t r;
    longint num, den, y, b1, b2, nb, acc;
    int n;
    bit clipped;
    r = '0;
    if (lo_bound == hi_bound) begin
      r.rerr = 1'b1;
      return r;
    end
    clipped = 1'b0;
    b1 = 0;
    b2 = 0;
    num = 2 * longint'(x) - longint'(lo_bound) - longint'(hi_bound);
    den = longint'(hi_bound) - longint'(lo_bound);
    y = clamp_q16(num * 65536 / den, clipped);
    n = (term_reg == 5'd0) ? 1 :
        (int'(term_reg) > cse_pkg::MAX_TERMS) ? cse_pkg::MAX_TERMS : int'(term_reg);
    for (int i = n - 1; i > 0; i--) begin
      nb = 2 * ((y * b1) >>> 16) - b2 + longint'(coef_tab[i]);
      b2 = b1;
      b1 = clamp_q16(nb, clipped);
    end
    acc = ((y * b1) >>> 16) - b2 + (longint'(coef_tab[0]) >>> 1);
    acc = clamp_q16(acc, clipped);
    r.value = acc[31:0];
    r.sat   = clipped;
    return r;
  endfunction

  // Mostly modest coefficients so sums stay in range; some full-scale ones.
  function automatic logic signed [31:0] pick_coef();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 32'($urandom_range(0, 'h4_0000)) - 32'h2_0000;
    if (sel < 15) return 32'($urandom_range(0, 'h8000)) - 32'h4000;
    if (sel < 18) return $urandom;
    return (sel == 18) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // Points inside the interval, with some anywhere in the Q16.16 range.
  function automatic logic signed [31:0] pick_x(input longint lo, input longint hi);
    longint base, width;
    longint unsigned r;
    if ($urandom_range(0, 9) == 0) return $urandom;
    base  = (lo < hi) ? lo : hi;
    width = (lo < hi) ? hi - lo : lo - hi;
    r = {$urandom, $urandom};
    return 32'(base + $signed(r % $unsigned(width + 1)));
  endfunction

  // Offer one item at a falling edge, wait for its transfer, record the
  // expectation. The sender runs in bursts with random gaps between them.
  task automatic send_item(input logic act, input logic [3:0] slot,
                           input logic signed [31:0] coef, input logic signed [31:0] xv,
                           input bit known, input series_result_t typed);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? int'($urandom_range(0, 12)) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    action     <= act;
    coef_index <= slot;
    coef_value <= coef;
    x_value    <= xv;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (act == cse_pkg::ACT_LOAD) coef_tab[slot] = coef;
    else pending.push_back(known ? typed : clenshaw_eval(xv));
    @(negedge clk);
  endtask

  // Drain: every result in, then enough cycles for a trailing load to finish.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller drops cfg_write after the last one.
  task automatic cfg_put(input logic [1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cse_pkg::CFG_LOWER: lo_bound = data;
      cse_pkg::CFG_UPPER: hi_bound = data;
      cse_pkg::CFG_TERMS: term_reg = data[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t row;
    series_result_t typed;
    bit cfg_open;
    int sent, phase_len, terms;
    longint lo, hi;
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = cse_pkg::ACT_EVAL;
    coef_index = 4'd0;
    coef_value = 32'sd0;
    x_value    = 32'sd0;
    cfg_write  = 1'b0;
    cfg_index  = cse_pkg::CFG_LOWER;
    cfg_data   = 32'd0;
    cfg_open   = 1'b0;
    foreach (coef_tab[i]) coef_tab[i] = 32'sd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. Consecutive config rows share one drain.
    foreach (DIRECTED[k]) begin
      row = DIRECTED[k];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) settle();
        cfg_put(row.reg_idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_write <= 1'b0;
          cfg_open = 1'b0;
        end
        typed = '{row.exp_value, row.exp_sat, row.exp_rerr};
        send_item((row.kind == ROW_LOAD) ? cse_pkg::ACT_LOAD : cse_pkg::ACT_EVAL,
                  row.slot, row.data, row.x, row.known, typed);
      end
    end

    // Random phases: new interval and term count, optionally a full table
    // reload, then a mix of loads and evaluations.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      case (span_kind_t'($urandom_range(0, 6)))
        SPAN_SYMMETRIC: begin
          lo = -longint'(Q_ONE);
          hi = longint'(Q_ONE);
        end
        SPAN_UNIT: begin
          lo = 0;
          hi = longint'(Q_ONE);
        end
        SPAN_RANDOM: begin
          lo = longint'($urandom_range(0, 200 * 65536)) - 100 * 65536;
          hi = lo + longint'($urandom_range(16, 16 * 65536));
        end
        SPAN_REVERSED: begin
          hi = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
          lo = hi + longint'($urandom_range(1, 4 * 65536));
        end
        SPAN_FULL: begin
          if ($urandom_range(0, 1) == 1) begin
            lo = Q_MIN;
            hi = Q_MAX;
          end else begin
            lo = longint'($signed($urandom));
            hi = longint'($signed($urandom));
          end
        end
        SPAN_EMPTY: begin
          lo = longint'($signed($urandom));
          hi = lo;
        end
        default: begin  // one LSB wide
          lo = longint'($urandom_range(0, 200 * 65536)) - 100 * 65536;
          hi = lo + 1;
        end
      endcase
      terms = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 31))
                                          : int'($urandom_range(1, 16));
      cfg_put(cse_pkg::CFG_LOWER, 32'(lo));
      cfg_put(cse_pkg::CFG_UPPER, 32'(hi));
      cfg_put(cse_pkg::CFG_TERMS, 32'(terms));
      cfg_write <= 1'b0;
      hold_req = 1'b1;  // receiver takes its long hold-off once, in the first phase
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        for (int s = 0; s < cse_pkg::MAX_TERMS; s++) begin
          send_item(cse_pkg::ACT_LOAD, 4'(s), pick_coef(), $urandom, 1'b0, '0);
          sent++;
        end
      end
      phase_len = $urandom_range(40, 120);
      for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 3)
          send_item(cse_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), pick_coef(), $urandom,
                    1'b0, '0);
        else
          send_item(cse_pkg::ACT_EVAL, 4'($urandom_range(0, 15)), $urandom, pick_x(lo, hi),
                    1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Output stall: segments of random length, each with its own stall density,
  // plus one long hold so the block backs up and stalls its input.
  initial begin : receiver
    stall_mode_t mode;
    int span;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      repeat (span) begin
        case (mode)
          FLOW:    out_stall <= 1'b0;
          LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          HALF:    out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    series_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected transfer: series_value %h", series_value);
        fails++;
      end else begin
        want = pending.pop_front();
        if (series_value !== want.value) begin
          $error("series_value: expected %h, got %h", want.value, series_value);
          fails++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated);
          fails++;
        end
        if (range_error !== want.rerr) begin
          $error("range_error: expected %b, got %b", want.rerr, range_error);
          fails++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block is stuck.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
hdl/cse_pkg.sv
hdl/cse_ram.sv
hdl/cse_dpath.sv
hdl/cse_ctrl.sv
hdl/chebyshev_series_evaluator.sv
tb/sv/testbench.sv
